[src/rbsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int FRAC_BITS       = 16;
  localparam int DIST_W          = 31;
  localparam int NORM_W          = 18;
  localparam int REG_IDX_W       = 3;

  localparam logic signed [NORM_W-1:0] ONE_Q16       = 18'sd65536;
  localparam logic signed [NORM_W-1:0] MINUS_ONE_Q16 = -18'sd65536;

  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

`default_nettype wire

[src/ray_box_slab_intersect_core.sv]
// Channel   Direction  Handshake                      Payload
// request   in         start_i, busy_o                origin_*_i, direction_*_i
// result    out        done_o (one-cycle strobe)      hit_o, hit_distance_o, normal_*_o
// config    in         cfg_valid_i, cfg_ready_o       cfg_index_i, cfg_data_i
//
// The core is fully pipelined and takes one request every cycle; busy_o stays low.
// The result latency is set by the normalize, square root and reciprocal divide chain.
// Reset clears the configuration registers and the valid pipeline only.
// Results cannot be stalled, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_core import rbsi_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [COORD_WIDTH-1:0]        origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]        origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]        origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]        direction_x_i,
  input  logic signed [COORD_WIDTH-1:0]        direction_y_i,
  input  logic signed [COORD_WIDTH-1:0]        direction_z_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0]                 cfg_index_i,
  input  logic [((COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W)-1:0] cfg_data_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic [DIST_W-1:0]                    hit_distance_o,
  output logic signed [NORM_W-1:0]             normal_x_o,
  output logic signed [NORM_W-1:0]             normal_y_o,
  output logic signed [NORM_W-1:0]             normal_z_o
);

  localparam int W      = COORD_WIDTH;
  localparam int NUM1_W = W + 1 + FRAC_BITS;
  localparam int NUM2_W = W + FRAC_BITS;
  localparam int K      = $clog2(W);
  localparam int TW     = ((W > DIST_W) ? W : DIST_W) + 1;
  localparam int LAT    = 22 + K + 2 * W;
  localparam int LAT1   = LAT + 1;
  localparam int DX     = W + K - 2;

  typedef struct packed {
    logic [2:0] neg_lo;
    logic [2:0] neg_hi;
    logic [2:0] zero;
    logic [2:0] outs;
  } slab_flags_t;

  typedef struct packed {
    logic                 hit;
    logic signed [TW-1:0] near;
    logic signed [TW-1:0] far;
    logic [1:0]           axis;
    logic                 pos_face;
  } trav_t;

  typedef struct packed {
    logic [W-1:0]        m;
    logic [2:0][W-1:0]   mag;
    logic [2:0]          dpos;
  } nrm_t;

  typedef struct packed {
    logic [2:0][W-1:0]   mag;
    logic [2:0]          dpos;
    logic                allz;
  } mside_t;

  typedef struct packed {
    logic [2:0] dpos;
    logic       allz;
  } nflag_t;

  // Configuration registers.
  logic [2:0][W-1:0]  box_min_q;
  logic [2:0][W-1:0]  box_max_q;
  logic [DIST_W-1:0]  max_dist_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q  <= '0;
      box_max_q  <= '0;
      max_dist_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BOX_MIN_X:    box_min_q[0] <= cfg_data_i[W-1:0];
        REG_BOX_MIN_Y:    box_min_q[1] <= cfg_data_i[W-1:0];
        REG_BOX_MIN_Z:    box_min_q[2] <= cfg_data_i[W-1:0];
        REG_BOX_MAX_X:    box_max_q[0] <= cfg_data_i[W-1:0];
        REG_BOX_MAX_Y:    box_max_q[1] <= cfg_data_i[W-1:0];
        REG_BOX_MAX_Z:    box_max_q[2] <= cfg_data_i[W-1:0];
        REG_MAX_DISTANCE: max_dist_q   <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid pipeline.
  logic [LAT:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-1:0], start_i & ~busy_o};
    end
  end

  assign done_o = v_q[LAT];

  // Input register.
  logic [2:0][W-1:0] org_q;
  logic [2:0][W-1:0] dir_q;

  always_ff @(posedge clk_i) begin
    org_q <= {origin_z_i, origin_y_i, origin_x_i};
    dir_q <= {direction_z_i, direction_y_i, direction_x_i};
  end

  // Stage 1: slab numerators, direction magnitudes and flags.
  logic [W:0]          dlo [3];
  logic [W:0]          dhi [3];
  logic [NUM1_W-1:0]   n_lo_d [3];
  logic [NUM1_W-1:0]   n_hi_d [3];
  logic [W-1:0]        dmag_d [3];
  slab_flags_t         fl1_d;
  logic [2:0]          dpos_d;

  logic [NUM1_W-1:0]   n_lo_q [3];
  logic [NUM1_W-1:0]   n_hi_q [3];
  logic [W-1:0]        dmag_q [3];
  slab_flags_t         fl1_q;
  logic [2:0]          dpos_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dlo[a] = {box_min_q[a][W-1], box_min_q[a]} - {org_q[a][W-1], org_q[a]};
      dhi[a] = {box_max_q[a][W-1], box_max_q[a]} - {org_q[a][W-1], org_q[a]};
      n_lo_d[a] = {(dlo[a][W] ? (W+1)'(-dlo[a]) : dlo[a]), {FRAC_BITS{1'b0}}};
      n_hi_d[a] = {(dhi[a][W] ? (W+1)'(-dhi[a]) : dhi[a]), {FRAC_BITS{1'b0}}};
      dmag_d[a] = dir_q[a][W-1] ? W'(-dir_q[a]) : dir_q[a];
      fl1_d.neg_lo[a] = dlo[a][W] ^ dir_q[a][W-1];
      fl1_d.neg_hi[a] = dhi[a][W] ^ dir_q[a][W-1];
      fl1_d.zero[a]   = (dir_q[a] == '0);
      fl1_d.outs[a]   = ($signed(org_q[a]) < $signed(box_min_q[a])) ||
                        ($signed(org_q[a]) > $signed(box_max_q[a]));
      dpos_d[a]       = !dir_q[a][W-1] && (dir_q[a] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    n_lo_q <= n_lo_d;
    n_hi_q <= n_hi_d;
    dmag_q <= dmag_d;
    fl1_q  <= fl1_d;
    dpos_q <= dpos_d;
  end

  // Slab dividers.
  logic [NUM1_W-1:0] qlo [3];
  logic [NUM1_W-1:0] qhi [3];

  for (genvar a = 0; a < 3; a++) begin : g_slab_div
    rbsi_div #(.NUM_W(NUM1_W), .DEN_W(W)) u_div_lo (
      .clk_i (clk_i),
      .num_i (n_lo_q[a]),
      .den_i (dmag_q[a]),
      .quo_o (qlo[a])
    );
    rbsi_div #(.NUM_W(NUM1_W), .DEN_W(W)) u_div_hi (
      .clk_i (clk_i),
      .num_i (n_hi_q[a]),
      .den_i (dmag_q[a]),
      .quo_o (qhi[a])
    );
  end

  slab_flags_t d1_q [NUM1_W];

  always_ff @(posedge clk_i) begin
    d1_q[0] <= fl1_q;
    for (int i = 1; i < NUM1_W; i++) begin
      d1_q[i] <= d1_q[i-1];
    end
  end

  // Sign and saturation.
  function automatic logic [W-1:0] sat_t(input logic [NUM1_W-1:0] mag, input logic neg);
    logic [NUM1_W-1:0] lim;
    logic [W-1:0]      res;
    lim = NUM1_W'(1) << (W - 1);
    if (neg) begin
      res = (mag >= lim) ? lim[W-1:0] : W'(-mag);
    end else begin
      res = (mag >= lim) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
    end
    return res;
  endfunction

  logic signed [W-1:0] t_lo_q [3];
  logic signed [W-1:0] t_hi_q [3];
  slab_flags_t         fl2_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      t_lo_q[a] <= sat_t(qlo[a], d1_q[NUM1_W-1].neg_lo[a]);
      t_hi_q[a] <= sat_t(qhi[a], d1_q[NUM1_W-1].neg_hi[a]);
    end
    fl2_q <= d1_q[NUM1_W-1];
  end

  // Ordering of the two plane distances per axis.
  logic signed [TW-1:0] tn_q   [3][3];
  logic signed [TW-1:0] tf_q   [3][3];
  logic [2:0]           face_q [3];
  slab_flags_t          fl3_q  [3];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (t_lo_q[a] > t_hi_q[a]) begin
        tn_q[0][a]   <= TW'(t_hi_q[a]);
        tf_q[0][a]   <= TW'(t_lo_q[a]);
        face_q[0][a] <= 1'b1;
      end else begin
        tn_q[0][a]   <= TW'(t_lo_q[a]);
        tf_q[0][a]   <= TW'(t_hi_q[a]);
        face_q[0][a] <= 1'b0;
      end
    end
    fl3_q[0] <= fl2_q;
  end

  // One stage per axis narrows the live interval.
  trav_t trav_q [3];
  trav_t trav_init;

  assign trav_init = '{hit: 1'b1, near: '0, far: TW'(max_dist_q), axis: AXIS_X,
                       pos_face: 1'b0};

  for (genvar k = 0; k < 3; k++) begin : g_axis
    trav_t prev;
    trav_t nxt;

    if (k == 0) begin : g_first
      assign prev = trav_init;
    end else begin : g_next
      assign prev = trav_q[k-1];
    end

    always_comb begin
      nxt = prev;
      if (prev.hit) begin
        if (fl3_q[k].zero[k]) begin
          if (fl3_q[k].outs[k]) begin
            nxt.hit = 1'b0;
          end
        end else begin
          if (tn_q[k][k] > $signed(prev.near)) begin
            nxt.near     = tn_q[k][k];
            nxt.axis     = 2'(k);
            nxt.pos_face = face_q[k][k];
          end
          if (tf_q[k][k] < $signed(prev.far)) begin
            nxt.far = tf_q[k][k];
          end
          if ($signed(nxt.near) > $signed(nxt.far)) begin
            nxt.hit = 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      trav_q[k] <= nxt;
    end

    if (k < 2) begin : g_carry
      always_ff @(posedge clk_i) begin
        tn_q[k+1]   <= tn_q[k];
        tf_q[k+1]   <= tf_q[k];
        face_q[k+1] <= face_q[k];
        fl3_q[k+1]  <= fl3_q[k];
      end
    end
  end

  trav_t d2_q [DX];

  always_ff @(posedge clk_i) begin
    d2_q[0] <= trav_q[2];
    for (int i = 1; i < DX; i++) begin
      d2_q[i] <= d2_q[i-1];
    end
  end

  // Inside-origin normal: largest magnitude, then normalize.
  nrm_t nz_q [K+1];

  always_ff @(posedge clk_i) begin
    logic [W-1:0] m01;
    m01 = (dmag_q[1] > dmag_q[0]) ? dmag_q[1] : dmag_q[0];
    nz_q[0].m    <= (dmag_q[2] > m01) ? dmag_q[2] : m01;
    nz_q[0].mag  <= {dmag_q[2], dmag_q[1], dmag_q[0]};
    nz_q[0].dpos <= dpos_q;
  end

  for (genvar j = 1; j <= K; j++) begin : g_norm
    localparam int SH = 1 << (K - j);
    logic do_sh;

    assign do_sh = ((nz_q[j-1].m >> (W - 1 - SH)) == '0);

    always_ff @(posedge clk_i) begin
      if (do_sh) begin
        nz_q[j].m <= nz_q[j-1].m << SH;
        for (int a = 0; a < 3; a++) begin
          nz_q[j].mag[a] <= nz_q[j-1].mag[a] << SH;
        end
      end else begin
        nz_q[j].m   <= nz_q[j-1].m;
        nz_q[j].mag <= nz_q[j-1].mag;
      end
      nz_q[j].dpos <= nz_q[j-1].dpos;
    end
  end

  logic [2*W-1:0] sq_q [3];
  mside_t         ms_sq_q;
  logic [2*W-1:0] s01_q;
  logic [2*W-1:0] sq2_q;
  mside_t         ms_a1_q;
  logic [2*W-1:0] sum_q;
  mside_t         ms_a2_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      sq_q[a] <= nz_q[K].mag[a] * nz_q[K].mag[a];
    end
    ms_sq_q.mag  <= nz_q[K].mag;
    ms_sq_q.dpos <= nz_q[K].dpos;
    ms_sq_q.allz <= (nz_q[K].m == '0);

    s01_q   <= sq_q[0] + sq_q[1];
    sq2_q   <= sq_q[2];
    ms_a1_q <= ms_sq_q;

    sum_q   <= s01_q + sq2_q;
    ms_a2_q <= ms_a1_q;
  end

  logic [W-1:0] len;

  rbsi_sqrt #(.ROOT_W(W)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (len)
  );

  mside_t d3_q [W];

  always_ff @(posedge clk_i) begin
    d3_q[0] <= ms_a2_q;
    for (int i = 1; i < W; i++) begin
      d3_q[i] <= d3_q[i-1];
    end
  end

  logic [NUM2_W-1:0] qn [3];

  for (genvar a = 0; a < 3; a++) begin : g_norm_div
    rbsi_div #(.NUM_W(NUM2_W), .DEN_W(W)) u_div_n (
      .clk_i (clk_i),
      .num_i ({d3_q[W-1].mag[a], {FRAC_BITS{1'b0}}}),
      .den_i (len),
      .quo_o (qn[a])
    );
  end

  nflag_t d4_q [NUM2_W];

  always_ff @(posedge clk_i) begin
    d4_q[0] <= '{dpos: d3_q[W-1].dpos, allz: d3_q[W-1].allz};
    for (int i = 1; i < NUM2_W; i++) begin
      d4_q[i] <= d4_q[i-1];
    end
  end

  // Result selection.
  trav_t                    res;
  nflag_t                   nf;
  logic signed [NORM_W-1:0] face;
  logic signed [NORM_W-1:0] nrm_d [3];
  logic [DIST_W-1:0]        dist_d;
  logic                     hit_d;

  assign res  = d2_q[DX-1];
  assign nf   = d4_q[NUM2_W-1];
  assign face = res.pos_face ? ONE_Q16 : MINUS_ONE_Q16;

  always_comb begin
    hit_d  = res.hit;
    dist_d = '0;
    for (int a = 0; a < 3; a++) begin
      nrm_d[a] = '0;
    end
    if (res.hit) begin
      dist_d = res.near[DIST_W-1:0];
      if ($signed(res.near) > 0) begin
        case (res.axis)
          AXIS_X:  nrm_d[0] = face;
          AXIS_Y:  nrm_d[1] = face;
          AXIS_Z:  nrm_d[2] = face;
          default: nrm_d[0] = face;
        endcase
      end else if (nf.allz) begin
        nrm_d[1] = ONE_Q16;
      end else begin
        for (int a = 0; a < 3; a++) begin
          nrm_d[a] = nf.dpos[a] ? -NORM_W'(qn[a][FRAC_BITS:0]) : NORM_W'(qn[a][FRAC_BITS:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o          <= hit_d;
    hit_distance_o <= dist_d;
    normal_x_o     <= nrm_d[0];
    normal_y_o     <= nrm_d[1];
    normal_z_o     <= nrm_d[2];
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT1 done_o)
    else $error("Accepted request did not produce a result at the pipeline depth.");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> hit_distance_o == '0 && normal_x_o == '0 &&
                         normal_y_o == '0 && normal_z_o == '0)
    else $error("Miss result carries nonzero distance or normal.");

  a_face_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o && hit_distance_o != '0 |->
      $onehot({normal_x_o != '0, normal_y_o != '0, normal_z_o != '0}))
    else $error("Entry face normal is not on a single axis.");
`endif

endmodule

`default_nettype wire

[src/rbsi_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      nq_q[s]  <= {nq_in[NUM_W-2:0], ge};
      den_q[s] <= den_in;
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

`default_nettype wire

[src/rbsi_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbsi_sqrt #(
  parameter int ROOT_W = 32
) (
  input  logic                  clk_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  logic [ROOT_W:0]       rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];
  logic [2*ROOT_W-1:0]   rad_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [ROOT_W:0]     rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [ROOT_W+2:0]   rem2;
    logic [ROOT_W+2:0]   trial;
    logic                ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign rem2  = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (ROOT_W+1)'(rem2 - trial) : rem2[ROOT_W:0];
      root_q[s] <= {root_in[ROOT_W-2:0], ge};
      rad_q[s]  <= {rad_in[2*ROOT_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire
